// ===== design/multi_mode_counter_display_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-mode counter display
// Immediate-style wrappers around concurrent properties, removable with
// ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_COUNTER_DISPLAY_TOP_ASSERT_SVH
`define MULTI_MODE_COUNTER_DISPLAY_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define MMCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// antecedent implies consequent in the next cycle
`define MMCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define MMCD_ASSERT_SAME(label, clk, rst, ante, cons)
`define MMCD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/mmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-mode counter display package
// Shared types, register map, mode codes and segment tables.
// ----------------------------------------------------------------------------
package mmcd_pkg;

   localparam int COUNT_W  = 10;
   localparam int PERIOD_W = 17;
   localparam int HOLDCFG_W = 20;
   localparam int SEG_W    = 7;
   localparam int MODE_W   = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CMP_W    = 32;

   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

   localparam logic [COUNT_W-1:0] AUTO_WRAP = 10'd101;
   localparam logic [COUNT_W-1:0] AUTO_TOP  = 10'd100;

   // reset values of the configuration registers
   localparam logic [COUNT_W-1:0]   RST_MIN_COUNT     = 10'd0;
   localparam logic [COUNT_W-1:0]   RST_MAX_COUNT     = 10'd100;
   localparam logic [PERIOD_W-1:0]  RST_REPEAT_PERIOD = 17'd10000;
   localparam logic [PERIOD_W-1:0]  RST_AUTO_PERIOD   = 17'd100000;
   localparam logic [HOLDCFG_W-1:0] RST_LONG_HOLD     = 20'd10000;
   localparam logic [HOLDCFG_W-1:0] RST_SHORT_HOLD    = 20'd100;

   // n/10 as (n*205)>>11, exact for n below 1029
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;
   localparam int RADIX       = 10;

   // active-low codes, bit0 = a .. bit6 = g
   localparam logic [SEG_W-1:0] SEG_CODE [10] = '{
      7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h18
   };

   typedef enum logic [2:0] {
      REG_MIN_COUNT     = 3'd0,
      REG_MAX_COUNT     = 3'd1,
      REG_REPEAT_PERIOD = 3'd2,
      REG_AUTO_PERIOD   = 3'd3,
      REG_LONG_HOLD     = 3'd4,
      REG_SHORT_HOLD    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0]   min_count;
      logic [COUNT_W-1:0]   max_count;
      logic [PERIOD_W-1:0]  repeat_period;
      logic [PERIOD_W-1:0]  auto_period;
      logic [HOLDCFG_W-1:0] long_hold;
      logic [HOLDCFG_W-1:0] short_hold;
   } cfg_type;

   typedef struct packed {
      logic               inc_pressed;
      logic               dec_pressed;
      logic               mode_pressed;
      logic               master_pressed;
      logic [COUNT_W-1:0] reading;
   } item_type;

   typedef struct packed {
      logic [MODE_W-1:0]  mode_now;
      logic [COUNT_W-1:0] shown_value;
      logic [SEG_W-1:0]   seg_units;
      logic [SEG_W-1:0]   seg_tens;
      logic [SEG_W-1:0]   seg_hundreds;
   } result_type;

endpackage

// ===== design/mmcd_csr.sv =====
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write/read access to the six limit and period registers.
// ----------------------------------------------------------------------------
module mmcd_csr import mmcd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_count     <= RST_MIN_COUNT;
         cfg_ff.max_count     <= RST_MAX_COUNT;
         cfg_ff.repeat_period <= RST_REPEAT_PERIOD;
         cfg_ff.auto_period   <= RST_AUTO_PERIOD;
         cfg_ff.long_hold     <= RST_LONG_HOLD;
         cfg_ff.short_hold    <= RST_SHORT_HOLD;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_MIN_COUNT:     cfg_ff.min_count     <= csr_pwdata[COUNT_W-1:0];
            REG_MAX_COUNT:     cfg_ff.max_count     <= csr_pwdata[COUNT_W-1:0];
            REG_REPEAT_PERIOD: cfg_ff.repeat_period <= csr_pwdata[PERIOD_W-1:0];
            REG_AUTO_PERIOD:   cfg_ff.auto_period   <= csr_pwdata[PERIOD_W-1:0];
            REG_LONG_HOLD:     cfg_ff.long_hold     <= csr_pwdata[HOLDCFG_W-1:0];
            REG_SHORT_HOLD:    cfg_ff.short_hold    <= csr_pwdata[HOLDCFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MIN_COUNT:     csr_prdata = CSR_DATA_W'(cfg_ff.min_count);
         REG_MAX_COUNT:     csr_prdata = CSR_DATA_W'(cfg_ff.max_count);
         REG_REPEAT_PERIOD: csr_prdata = CSR_DATA_W'(cfg_ff.repeat_period);
         REG_AUTO_PERIOD:   csr_prdata = CSR_DATA_W'(cfg_ff.auto_period);
         REG_LONG_HOLD:     csr_prdata = CSR_DATA_W'(cfg_ff.long_hold);
         REG_SHORT_HOLD:    csr_prdata = CSR_DATA_W'(cfg_ff.short_hold);
         default:           csr_prdata = '0;
      endcase
   end

endmodule

// ===== design/mmcd_seg.sv =====
// ----------------------------------------------------------------------------
// Three-digit seven-segment decoder
// Splits a 10-bit value into decimal digits and maps each to its segments.
// ----------------------------------------------------------------------------
module mmcd_seg import mmcd_pkg::*; (
   input  logic [COUNT_W-1:0] value,
   output logic [SEG_W-1:0]   seg_units,
   output logic [SEG_W-1:0]   seg_tens,
   output logic [SEG_W-1:0]   seg_hundreds
);

   logic [17:0]        prod10;
   logic [6:0]         q10;
   logic [14:0]        prod100;
   logic [3:0]         q100;
   logic [COUNT_W-1:0] q10_x10;
   logic [6:0]         q100_x10;
   logic [3:0]         units;
   logic [3:0]         tens;
   logic [3:0]         hundreds;

   // reciprocal multiply, one shift-add network per digit split
   assign prod10   = 18'(value) * 18'(DIV10_MUL);
   assign q10      = 7'(prod10 >> DIV10_SHIFT);
   assign prod100  = 15'(q10) * 15'(DIV10_MUL);
   assign q100     = 4'(prod100 >> DIV10_SHIFT);

   assign q10_x10  = COUNT_W'(q10) * COUNT_W'(RADIX);
   assign q100_x10 = 7'(q100) * 7'(RADIX);
   assign units    = 4'(value - q10_x10);
   assign tens     = 4'(q10 - q100_x10);
   // values of 1000 and up wrap the hundreds digit
   assign hundreds = (q100 >= 4'(RADIX)) ? 4'(q100 - 4'(RADIX)) : q100;

   assign seg_units    = SEG_CODE[units];
   assign seg_tens     = SEG_CODE[tens];
   assign seg_hundreds = SEG_CODE[hundreds];

endmodule

// ===== design/mmcd_core.sv =====
// ----------------------------------------------------------------------------
// Counter core
// Mode, count, timer and hold state with the per-transaction update.
// ----------------------------------------------------------------------------
`include "multi_mode_counter_display_top_assert.svh"

module mmcd_core import mmcd_pkg::*; #(
   parameter int TIMER_BITS = 17,
   parameter int HOLD_BITS  = 20
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
   localparam logic [HOLD_BITS-1:0]  HOLD_MAX  = '1;

   logic [MODE_W-1:0]     mode_ff,  mode_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [HOLD_BITS-1:0]  hold_ff,  hold_in;
   logic [COUNT_W-1:0]    shown;
   logic                  is_manual;

   // display reflects the state before this transaction's update
   assign shown     = (mode_ff == MODE_READ) ? item.reading : count_ff;
   assign is_manual = (mode_ff != MODE_AUTO) && (mode_ff != MODE_READ);

   mmcd_seg u_seg (
      .value        (shown),
      .seg_units    (result.seg_units),
      .seg_tens     (result.seg_tens),
      .seg_hundreds (result.seg_hundreds)
   );

   assign result.mode_now    = mode_ff;
   assign result.shown_value = shown;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      timer_in = timer_ff;
      hold_in  = hold_ff;

      // manual stepping, inc then dec
      if (is_manual && (CMP_W'(timer_ff) >= CMP_W'(cfg.repeat_period))) begin
         if (item.inc_pressed) begin
            count_in = (count_in >= cfg.max_count) ? cfg.min_count : count_in + 10'd1;
            timer_in = '0;
         end
         if (item.dec_pressed) begin
            count_in = (count_in <= cfg.min_count) ? cfg.max_count : count_in - 10'd1;
            timer_in = '0;
         end
      end

      // mode button: count while held, judge the hold when released
      if (item.mode_pressed) begin
         if (hold_ff != HOLD_MAX) begin
            hold_in = hold_ff + 1'b1;
         end
      end else if (CMP_W'(hold_ff) >= CMP_W'(cfg.long_hold)) begin
         hold_in  = '0;
         count_in = '0;
         timer_in = '0;
         mode_in  = (mode_ff == MODE_READ) ? MODE_MANUAL : mode_ff + 2'd1;
      end else if ((CMP_W'(hold_ff) >= CMP_W'(cfg.short_hold)) && (hold_ff != '0)) begin
         hold_in  = '0;
         count_in = '0;
      end

      // auto increment sees the state after the button update
      if (mode_ff == MODE_AUTO) begin
         if (CMP_W'(timer_in) >= CMP_W'(cfg.auto_period)) begin
            count_in = count_in + 10'd1;
            timer_in = '0;
            if (count_in >= AUTO_WRAP) begin
               count_in = '0;
            end
         end
      end

      if (mode_ff != MODE_READ) begin
         timer_in = (timer_in == TIMER_MAX) ? timer_in : timer_in + 1'b1;
      end

      if (item.master_pressed) begin
         mode_in  = MODE_MANUAL;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_MANUAL;
         count_ff <= '0;
         timer_ff <= '0;
         hold_ff  <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         timer_ff <= timer_in;
         hold_ff  <= hold_in;
      end
   end

   `MMCD_ASSERT_SAME(a_auto_count_range, clock, reset, mode_ff == MODE_AUTO, count_ff <= AUTO_TOP)
   `MMCD_ASSERT_NEXT(a_master_clears, clock, reset, step && item.master_pressed, (mode_ff == MODE_MANUAL) && (count_ff == '0))
   `MMCD_ASSERT_NEXT(a_hold_saturates, clock, reset, step && item.mode_pressed && (hold_ff == HOLD_MAX), hold_ff == HOLD_MAX)

endmodule

// ===== design/multi_mode_counter_display_top.sv =====
// ----------------------------------------------------------------------------
// Multi-mode counter display, top level
// Counter with manual, automatic and reading modes driving three digits.
// ----------------------------------------------------------------------------
// One transaction is one time tick of button levels plus a reading. The block
// accepts a transaction every clock cycle while the result side does not stall
// and returns exactly one result per transaction, held first in the input
// register and then in the result register. The whole state update (step,
// button judgment, auto increment, timer) is combinational logic closed on
// the core state registers, which sets the one-per-cycle rate.
// The result shows the mode and value in force before that tick's update.
// Configuration registers sit at byte addresses 0, 4, .. 20; the user must
// write them only while no transaction is in flight; nothing here enforces it.
`include "multi_mode_counter_display_top_assert.svh"

module multi_mode_counter_display_top import mmcd_pkg::*; #(
   parameter int TIMER_BITS = 17,
   parameter int HOLD_BITS  = 20
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_inc_pressed,
   input  logic                  req_dec_pressed,
   input  logic                  req_mode_pressed,
   input  logic                  req_master_pressed,
   input  logic [COUNT_W-1:0]    req_reading,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MODE_W-1:0]     rsp_mode_now,
   output logic [COUNT_W-1:0]    rsp_shown_value,
   output logic [SEG_W-1:0]      rsp_seg_units,
   output logic [SEG_W-1:0]      rsp_seg_tens,
   output logic [SEG_W-1:0]      rsp_seg_hundreds,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type    cfg;
   item_type   in_item_ff;
   logic       in_valid_ff, in_valid_in;
   result_type core_result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       advance;
   logic       step;

   mmcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // result register frees up when empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   mmcd_core #(
      .TIMER_BITS (TIMER_BITS),
      .HOLD_BITS  (HOLD_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.inc_pressed    <= req_inc_pressed;
         in_item_ff.dec_pressed    <= req_dec_pressed;
         in_item_ff.mode_pressed   <= req_mode_pressed;
         in_item_ff.master_pressed <= req_master_pressed;
         in_item_ff.reading        <= req_reading;
      end
      if (step) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode_now     = rsp_ff.mode_now;
   assign rsp_shown_value  = rsp_ff.shown_value;
   assign rsp_seg_units    = rsp_ff.seg_units;
   assign rsp_seg_tens     = rsp_ff.seg_tens;
   assign rsp_seg_hundreds = rsp_ff.seg_hundreds;

   `MMCD_ASSERT_SAME(a_rsp_mode_legal, clock, reset, rsp_valid_ff, rsp_ff.mode_now != 2'd0)
   `MMCD_ASSERT_NEXT(a_step_fills_rsp, clock, reset, step, rsp_valid_ff)
   `MMCD_ASSERT_NEXT(a_held_input_kept, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule
